// ===== src/bfpr_pkg.sv =====
// ----------------------------------------------------------------------------
// bfpr_pkg
// shared types and constants of the pull-style edge relaxation engine
// ----------------------------------------------------------------------------
package bfpr_pkg;

  localparam int NODES       = 1024;
  localparam int NODE_W      = $clog2(NODES);
  localparam int DIST_W      = 30;
  localparam int WEIGHT_W    = 24;
  localparam int OP_W        = 3;
  localparam int OWN_W       = 11;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;

  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

  localparam logic [OP_W-1:0] OPC_INIT   = 3'd0;
  localparam logic [OP_W-1:0] OPC_SET    = 3'd1;
  localparam logic [OP_W-1:0] OPC_READ   = 3'd2;
  localparam logic [OP_W-1:0] OPC_RELAX  = 3'd3;
  localparam logic [OP_W-1:0] OPC_COMMIT = 3'd4;

  typedef enum logic [2:0] {
    K_INIT,
    K_SET,
    K_READ,
    K_RELAX,
    K_COMMIT,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [NODE_W-1:0]   node;
    logic [NODE_W-1:0]   neighbour;
    logic [WEIGHT_W-1:0] weight;
    logic                edge_valid;
    logic                last_edge;
    logic [DIST_W-1:0]   value;
  } item_t;

endpackage

// ===== src/bfpr_ram.sv =====
// ----------------------------------------------------------------------------
// bfpr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bfpr_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bfpr_front.sv =====
// ----------------------------------------------------------------------------
// bfpr_front
// accepts input transactions, decodes the opcode and queues the items
// ----------------------------------------------------------------------------
module bfpr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bfpr_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [bfpr_pkg::OP_W-1:0]        in_tuser,
  input  logic                             in_tlast,
  output logic                             q_valid,
  output bfpr_pkg::item_t                  q_item,
  input  logic                             q_pop
);
  import bfpr_pkg::*;

  item_t              q_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic [QCNT_W-1:0]  cnt_nxt;
  item_t              dec;
  logic               push;

  always_comb begin
    unique case (in_tuser)
      OPC_INIT:   dec.kind = K_INIT;
      OPC_SET:    dec.kind = K_SET;
      OPC_READ:   dec.kind = K_READ;
      OPC_RELAX:  dec.kind = K_RELAX;
      OPC_COMMIT: dec.kind = K_COMMIT;
      default:    dec.kind = K_NOP;
    endcase
    dec.node       = in_tdata[9:0];
    dec.neighbour  = in_tdata[19:10];
    dec.weight     = in_tdata[43:20];
    dec.edge_valid = in_tdata[44];
    dec.last_edge  = in_tlast;
    dec.value      = in_tdata[74:45];
  end

  assign in_tready = (cnt_r != QCNT_W'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/bfpr_back.sv =====
// ----------------------------------------------------------------------------
// bfpr_back
// sequencer that reads the distance copies, relaxes edges and drives results
// ----------------------------------------------------------------------------
module bfpr_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bfpr_pkg::OWN_W-1:0]       cfg_wdata,
  input  logic                             q_valid,
  input  bfpr_pkg::item_t                  q_item,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bfpr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bfpr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_RD_NODE  = 4'b0010,
    S_RD_NBR   = 4'b0100,
    S_EXEC     = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  item_t              item_r;
  logic [OWN_W-1:0]   owned_r;
  logic               phase_r;
  logic               mid_node_r;
  logic               change_r;
  logic [DIST_W-1:0]  run_min_r;
  logic [DIST_W-1:0]  cur_n_r;
  logic [DIST_W-1:0]  nxt_n_r;
  logic [DIST_W-1:0]  cand_r;

  logic               out_valid_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               out_low_r;
  logic               out_chg_r;

  logic [NODE_W-1:0]  raddr;
  logic [DIST_W-1:0]  a_q, b_q;
  logic               we_a, we_b;
  logic [DIST_W-1:0]  wdata;

  logic               out_free;
  logic               fire;
  logic               ver_n;
  logic               ver_nb;
  logic [DIST_W-1:0]  base;
  logic [DIST_W-1:0]  new_min;
  logic               lower;
  logic [DIST_W:0]    sum;

  function automatic logic cur_ver(input logic [NODE_W-1:0] n,
                                   input logic [OWN_W-1:0] owned,
                                   input logic ph);
    return (OWN_W'(n) < owned) ? ph : 1'b0;
  endfunction

  bfpr_ram #(.WIDTH(DIST_W), .DEPTH(NODES)) u_copy_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (item_r.node),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (a_q)
  );

  bfpr_ram #(.WIDTH(DIST_W), .DEPTH(NODES)) u_copy_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (item_r.node),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (b_q)
  );

  assign out_free = !out_valid_r || out_tready;
  assign fire     = (state_r == S_EXEC) && out_free;
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign ver_n    = cur_ver(item_r.node, owned_r, phase_r);
  assign ver_nb   = cur_ver(item_r.neighbour, owned_r, phase_r);

  always_comb begin
    unique case (state_r)
      S_IDLE:    raddr = q_item.node;
      S_RD_NODE: raddr = item_r.neighbour;
      default:   raddr = item_r.node;
    endcase
  end

  // neighbour distance plus weight, one bit wider so the carry can saturate
  assign sum = {1'b0, (ver_nb ? b_q : a_q)} + (DIST_W + 1)'(item_r.weight);

  always_comb begin
    base    = mid_node_r ? run_min_r : cur_n_r;
    new_min = (item_r.edge_valid && (cand_r < base)) ? cand_r : base;
    lower   = item_r.last_edge && (new_min < nxt_n_r);
  end

  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    wdata = new_min;
    if (fire) begin
      unique case (item_r.kind)
        K_INIT: begin
          we_a  = 1'b1;
          we_b  = 1'b1;
          wdata = DIST_INF;
        end
        K_SET: begin
          we_a  = !ver_n;
          we_b  = ver_n;
          wdata = item_r.value;
        end
        K_RELAX: begin
          we_a  = lower && ver_n;
          we_b  = lower && !ver_n;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (q_valid) state_nxt = S_RD_NODE;
      S_RD_NODE: state_nxt = (item_r.kind == K_RELAX) ? S_RD_NBR : S_EXEC;
      S_RD_NBR:  state_nxt = S_EXEC;
      S_EXEC:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (state_r == S_RD_NODE) begin
      cur_n_r <= ver_n ? b_q : a_q;
      nxt_n_r <= ver_n ? a_q : b_q;
    end
    if (state_r == S_RD_NBR) begin
      cand_r <= sum[DIST_W] ? DIST_INF : sum[DIST_W-1:0];
    end
    if (fire) begin
      unique case (item_r.kind)
        K_READ: begin
          out_dist_r <= cur_n_r;
          out_low_r  <= 1'b0;
          out_chg_r  <= 1'b0;
        end
        K_RELAX: begin
          out_dist_r <= new_min;
          out_low_r  <= lower;
          out_chg_r  <= 1'b0;
        end
        K_COMMIT: begin
          out_dist_r <= '0;
          out_low_r  <= 1'b0;
          out_chg_r  <= change_r;
        end
        default: begin
          out_dist_r <= '0;
          out_low_r  <= 1'b0;
          out_chg_r  <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      owned_r     <= '0;
      phase_r     <= 1'b0;
      mid_node_r  <= 1'b0;
      change_r    <= 1'b0;
      run_min_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        owned_r <= cfg_wdata;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (fire && item_r.kind == K_RELAX) begin
        run_min_r  <= new_min;
        mid_node_r <= !item_r.last_edge;
        if (lower) begin
          change_r <= 1'b1;
        end
      end
      if (fire && item_r.kind == K_COMMIT) begin
        phase_r  <= !phase_r;
        change_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_chg_r, out_low_r, out_dist_r};

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (we_a || we_b) |-> (state_r == S_EXEC))
    else $error("distance copy written outside execute");

  a_lower_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item_r.kind == K_RELAX && lower) |=> change_r)
    else $error("lowered relax did not set change flag");

  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item_r.kind == K_COMMIT) |=> (!change_r && out_valid_r))
    else $error("commit did not clear change flag");

  a_lowered_finite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_low_r) |-> (out_dist_r != DIST_INF))
    else $error("lowered result carries infinite distance");

endmodule

// ===== src/bellman_ford_pull_relax.sv =====
// ----------------------------------------------------------------------------
// bellman_ford_pull_relax
// pull-style edge relaxation engine with double-buffered node distances
// ----------------------------------------------------------------------------
//  channel | direction | handshake                     | payload
//  in_     | input     | in_tvalid / in_tready         | in_tdata, in_tuser, in_tlast
//  out_    | output    | out_tvalid / out_tready       | out_tdata
//  cfg_    | input     | cfg_we                        | cfg_wdata (owned_count)
//
// the back sequencer steps each transaction through idle, node read and execute, a relax
// also through a neighbour read, reading both distance copies at the node and then at the neighbour
// synchronous active-low reset; distance memories are not cleared
// a 4-entry queue between front and back absorbs input bursts
// the output register holds a result while out_tready is low
// ----------------------------------------------------------------------------
module bellman_ford_pull_relax (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // node, neighbour, weight, edge_valid, value, zero fill
  input  logic [bfpr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [bfpr_pkg::OP_W-1:0]        in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // distance, lowered, changed
  output logic [bfpr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [bfpr_pkg::OWN_W-1:0]       cfg_wdata
);
  import bfpr_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  bfpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  bfpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stream-level testbench of the pull-style edge relaxation engine: a directed
// table walks init, set, read, relax streams, commit, saturation and reserved
// opcodes, then randomized relax streams with noise run under several owned
// node counts; each result is checked against its table row or a model of the
// double-buffered distance store, with bursty input and a stalling receiver
// ----------------------------------------------------------------------------
module tb_top;
  import bfpr_pkg::*;

  localparam logic [OP_W-1:0] OPC_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OPC_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OPC_RSVD7 = 3'd7;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 215;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int FILL_W       = IN_TDATA_W - DIST_W - WEIGHT_W - 2 * NODE_W - 1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    node_t               node;
    node_t               neighbour;
    logic [WEIGHT_W-1:0] weight;
    logic                edge_valid;
    logic                last_edge;
    dist_t               value;
  } req_t;

  typedef struct packed {
    dist_t distance;
    logic  lowered;
    logic  changed;
  } result_t;

  typedef struct {
    req_t    req;
    bit      typed;
    result_t res;
  } row_t;

  localparam result_t NO_RESULT = '0;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [OWN_W-1:0]       cfg_wdata;

  // model of the distance store
  dist_t            copy_a [NODES];
  dist_t            copy_b [NODES];
  bit               wr_a   [NODES];
  bit               wr_b   [NODES];
  logic             phase_bit     = 1'b0;
  logic             in_stream     = 1'b0;
  logic             round_changed = 1'b0;
  dist_t            run_min       = '0;
  logic [OWN_W-1:0] owned         = '0;

  result_t expected_q [$];
  row_t    dir_rows [$];
  node_t   pool [8];
  int      errors     = 0;
  int      burst_left = 0;
  int      cycle_cnt  = 0;
  bit      hold_req   = 1'b0;

  bellman_ford_pull_relax u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void queue_expected(result_t res);
    expected_q.insert(expected_q.size(), res);
  endfunction

  function automatic void add_row(req_t req, bit typed, result_t res);
    row_t row;
    row.req   = req;
    row.typed = typed;
    row.res   = res;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic logic cur_copy(node_t n);
    return ({1'b0, n} < owned) ? phase_bit : 1'b0;
  endfunction

  function automatic dist_t read_copy(node_t n, logic v);
    return v ? copy_b[n] : copy_a[n];
  endfunction

  function automatic bit is_written(node_t n, logic v);
    return v ? wr_b[n] : wr_a[n];
  endfunction

  function automatic void write_copy(node_t n, logic v, dist_t d);
    if (v) begin
      copy_b[n] = d;
      wr_b[n]   = 1'b1;
    end else begin
      copy_a[n] = d;
      wr_a[n]   = 1'b1;
    end
  endfunction

  function automatic result_t relax_engine_step(req_t r);
    result_t          res;
    logic [DIST_W:0]  sum;
    logic             nv;
    res = '0;
    case (r.opcode)
      OPC_INIT: begin
        write_copy(r.node, 1'b0, DIST_INF);
        write_copy(r.node, 1'b1, DIST_INF);
      end
      OPC_SET: write_copy(r.node, cur_copy(r.node), r.value);
      OPC_READ: res.distance = read_copy(r.node, cur_copy(r.node));
      OPC_RELAX: begin
        if (!in_stream) run_min = read_copy(r.node, cur_copy(r.node));
        if (r.edge_valid) begin
          sum = {1'b0, read_copy(r.neighbour, cur_copy(r.neighbour))}
                + (DIST_W + 1)'(r.weight);
          if (sum > {1'b0, DIST_INF}) sum = {1'b0, DIST_INF};
          if (sum[DIST_W-1:0] < run_min) run_min = sum[DIST_W-1:0];
        end
        if (r.last_edge) begin
          nv = ~cur_copy(r.node);
          if (run_min < read_copy(r.node, nv)) begin
            write_copy(r.node, nv, run_min);
            round_changed = 1'b1;
            res.lowered   = 1'b1;
          end
          in_stream = 1'b0;
        end else begin
          in_stream = 1'b1;
        end
        res.distance = run_min;
      end
      OPC_COMMIT: begin
        phase_bit     = ~phase_bit;
        res.changed   = round_changed;
        round_changed = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // finds a node whose distance this transaction would read before any write
  function automatic bit needs_init(req_t r, output node_t bad);
    bad = r.node;
    if (r.opcode == OPC_READ) return !is_written(r.node, cur_copy(r.node));
    if (r.opcode != OPC_RELAX) return 1'b0;
    if (!in_stream && !is_written(r.node, cur_copy(r.node))) return 1'b1;
    if (r.last_edge && !is_written(r.node, ~cur_copy(r.node))) return 1'b1;
    bad = r.neighbour;
    return r.edge_valid && !is_written(r.neighbour, cur_copy(r.neighbour));
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.opcode     = OP_W'($urandom_range(0, 7));
    r.node       = node_t'($urandom_range(0, NODES - 1));
    r.neighbour  = node_t'($urandom_range(0, NODES - 1));
    r.weight     = WEIGHT_W'($urandom);
    r.edge_valid = 1'($urandom_range(0, 1));
    r.last_edge  = 1'($urandom_range(0, 1));
    r.value      = dist_t'($urandom);
    return r;
  endfunction

  function automatic req_t mk_req(logic [OP_W-1:0] op, node_t n, node_t nb,
                                  logic [WEIGHT_W-1:0] w, logic ev, logic last, dist_t v);
    req_t r;
    r = '{opcode: op, node: n, neighbour: nb, weight: w, edge_valid: ev,
          last_edge: last, value: v};
    return r;
  endfunction

  function automatic result_t res_of(dist_t d, logic l, logic c);
    result_t res;
    res = '{distance: d, lowered: l, changed: c};
    return res;
  endfunction

  function automatic dist_t rand_dist();
    case ($urandom_range(0, 4))
      0: return dist_t'($urandom_range(0, 5000));
      1: return DIST_INF;
      2: return dist_t'(DIST_INF - $urandom_range(0, 20'hFFFFF));
      3: return '0;
      default: return dist_t'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return WEIGHT_W'($urandom_range(0, 1000));
      1: return {WEIGHT_W{1'b1}};
      2: return WEIGHT_W'($urandom_range(0, 65535));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic node_t pick_node();
    if ($urandom_range(0, 7) == 0) return node_t'($urandom_range(0, NODES - 1));
    return pool[$urandom_range(0, 7)];
  endfunction

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_item(req_t r, bit typed, result_t typed_res);
    result_t pred;
    in_tvalid <= 1'b1;
    in_tdata  <= {{FILL_W{1'b0}}, r.value, r.edge_valid, r.weight, r.neighbour, r.node};
    in_tuser  <= r.opcode;
    in_tlast  <= r.last_edge;
    do @(posedge clk); while (!in_tready);
    pred = relax_engine_step(r);
    queue_expected(typed ? typed_res : pred);
    pace();
  endtask

  // primes never-written nodes with an init before the transaction goes out
  task automatic issue(req_t r, bit typed, result_t typed_res);
    node_t bad;
    req_t  prime;
    while (needs_init(r, bad)) begin
      prime        = rand_req();
      prime.opcode = OPC_INIT;
      prime.node   = bad;
      send_item(prime, 1'b0, NO_RESULT);
    end
    send_item(r, typed, typed_res);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_owned(logic [OWN_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    owned      = v;
  endtask

  task automatic run_phase(int n_items);
    int    done;
    int    len;
    int    pick;
    node_t tgt;
    req_t  r;
    for (int i = 0; i < 4; i++) pool[i] = node_t'(i);
    pool[4] = (owned == 0) ? '0 : (owned > NODES) ? node_t'(NODES - 1) : node_t'(owned - 1);
    pool[5] = (owned >= NODES) ? node_t'(NODES - 2) : node_t'(owned);
    pool[6] = node_t'($urandom_range(0, NODES - 1));
    pool[7] = node_t'(NODES - 1);
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      r    = rand_req();
      if (pick < 50) begin
        tgt = pick_node();
        len = $urandom_range(1, 5);
        for (int e = 0; e < len; e++) begin
          r            = rand_req();
          r.opcode     = OPC_RELAX;
          r.node       = ($urandom_range(0, 19) == 0) ? pick_node() : tgt;
          r.neighbour  = pick_node();
          r.weight     = rand_weight();
          r.edge_valid = ($urandom_range(0, 7) != 0);
          r.last_edge  = (e == len - 1) && ($urandom_range(0, 29) != 0);
          issue(r, 1'b0, NO_RESULT);
          done++;
          if ($urandom_range(0, 9) == 0) begin
            r = rand_req();
            case ($urandom_range(0, 2))
              0: r.opcode = OPC_READ;
              1: r.opcode = OPC_SET;
              default: r.opcode = OPC_COMMIT;
            endcase
            r.node  = pick_node();
            r.value = rand_dist();
            issue(r, 1'b0, NO_RESULT);
            done++;
          end
        end
      end else begin
        r.node = pick_node();
        if (pick < 62) begin
          r.opcode = OPC_SET;
          r.value  = rand_dist();
        end else if (pick < 74) begin
          r.opcode = OPC_READ;
        end else if (pick < 82) begin
          r.opcode = OPC_INIT;
        end else if (pick < 90) begin
          r.opcode = OPC_COMMIT;
        end else if (pick < 95) begin
          case ($urandom_range(0, 2))
            0: r.opcode = OPC_RSVD5;
            1: r.opcode = OPC_RSVD6;
            default: r.opcode = OPC_RSVD7;
          endcase
        end else begin
          r.opcode    = OPC_RELAX;
          r.neighbour = pick_node();
          r.weight    = rand_weight();
        end
        issue(r, 1'b0, NO_RESULT);
        done++;
      end
    end
  endtask

  // receiver: stall pattern of its own, plus one long hold-off
  initial begin
    int  mode;
    int  stretch;
    bit  hold_done;
    out_tready = 1'b0;
    mode       = 0;
    stretch    = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 2);
          stretch = $urandom_range(5, 60);
        end
        stretch--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.distance = out_tdata[DIST_W-1:0];
      got.lowered  = out_tdata[DIST_W];
      got.changed  = out_tdata[DIST_W+1];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, actual %h", $time, out_tdata);
      end else begin
        want = expected_q.pop_front();
        if (got.distance !== want.distance) begin
          errors++;
          $display("%0t: distance mismatch, expected %h, actual %h",
                   $time, want.distance, got.distance);
        end
        if (got.lowered !== want.lowered) begin
          errors++;
          $display("%0t: lowered mismatch, expected %b, actual %b",
                   $time, want.lowered, got.lowered);
        end
        if (got.changed !== want.changed) begin
          errors++;
          $display("%0t: changed mismatch, expected %b, actual %b",
                   $time, want.changed, got.changed);
        end
      end
    end
  end

  initial begin
    logic [OWN_W-1:0] owned_vals [6];
    req_t             r;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OPC_INIT;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    owned_vals = '{11'd1024, 11'd2047, 11'd7, 11'd0, 11'd1, 11'd0};
    owned_vals[3] = OWN_W'($urandom_range(2, 1023));

    add_row(mk_req(OPC_INIT, 0, 0, 0, 0, 0, 0), 1, NO_RESULT);
    add_row(mk_req(OPC_INIT, 1023, 0, 0, 0, 0, 0), 1, NO_RESULT);
    add_row(mk_req(OPC_READ, 0, 0, 0, 0, 0, 0), 1, res_of(DIST_INF, 0, 0));
    add_row(mk_req(OPC_READ, 1023, 0, 0, 0, 0, 0), 1, res_of(DIST_INF, 0, 0));
    add_row(mk_req(OPC_SET, 0, 0, 0, 0, 0, 0), 1, NO_RESULT);
    add_row(mk_req(OPC_READ, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 0));
    add_row(mk_req(OPC_SET, 1023, 0, 0, 0, 0, DIST_INF), 1, NO_RESULT);
    add_row(mk_req(OPC_INIT, 1, 0, 0, 0, 0, 0), 1, NO_RESULT);
    add_row(mk_req(OPC_SET, 1, 0, 0, 0, 0, 100), 1, NO_RESULT);
    // max weight from a zero-distance neighbour lowers an unreachable node
    add_row(mk_req(OPC_RELAX, 1023, 0, 24'hFFFFFF, 1, 1, 0), 0, NO_RESULT);
    add_row(mk_req(OPC_COMMIT, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 1));
    add_row(mk_req(OPC_COMMIT, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 0));
    // saturating sum, then interleaved read, then stream end without an edge
    add_row(mk_req(OPC_RELAX, 1, 1023, 24'hFFFFFF, 1, 0, 0), 0, NO_RESULT);
    add_row(mk_req(OPC_READ, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 0));
    add_row(mk_req(OPC_RELAX, 1, 0, 5, 1, 0, 0), 0, NO_RESULT);
    add_row(mk_req(OPC_RELAX, 1, 0, 0, 0, 1, 0), 0, NO_RESULT);
    add_row(mk_req(OPC_RELAX, 0, 0, 0, 0, 1, 0), 0, NO_RESULT);
    r = rand_req();
    r.opcode = OPC_RSVD5;
    add_row(r, 1, NO_RESULT);
    r = rand_req();
    r.opcode = OPC_RSVD6;
    add_row(r, 1, NO_RESULT);
    add_row(mk_req(OPC_RSVD7, 1023, 1023, 24'hFFFFFF, 1, 1, DIST_INF), 1, NO_RESULT);
    add_row(mk_req(OPC_SET, 1, 0, 0, 0, 0, DIST_INF - 1), 1, NO_RESULT);
    // commit in the middle of a stream
    add_row(mk_req(OPC_RELAX, 0, 0, 0, 0, 0, 0), 0, NO_RESULT);
    add_row(mk_req(OPC_COMMIT, 0, 0, 0, 0, 0, 0), 1, res_of(0, 0, 1));
    add_row(mk_req(OPC_RELAX, 1, 0, 0, 1, 1, 0), 0, NO_RESULT);
    add_row(mk_req(OPC_READ, 1023, 0, 0, 0, 0, 0), 1, res_of(DIST_INF, 0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    drain();

    foreach (owned_vals[p]) begin
      write_owned(owned_vals[p]);
      if (p == 1) hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
      drain();
    end

    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== bellman_ford_pull_relax.f =====
src/bfpr_pkg.sv
src/bfpr_ram.sv
src/bfpr_front.sv
src/bfpr_back.sv
src/bellman_ford_pull_relax.sv
tb/sv/tb_top.sv
